// ----- hw/rtl/grpc_pkg.sv -----
// Shared constants for the greedy relaxed-plan cost core.
// Used by grpc_cell and greedy_relaxed_plan_cost_core; no dependencies.
package grpc_pkg;

	localparam int DATA_W    = 64;  // width of masks and of the config data port
	localparam int IDX_W     = 8;   // width of the op_index field
	localparam int OPCOST_W  = 16;  // width of one operator cost
	localparam int COST_W    = 24;  // width of the accumulated plan cost
	localparam int COUNT_W   = 9;   // width of the operator_count register
	localparam int CFG_IDX_W = 1;

	localparam logic OPC_LOAD  = 1'b0;
	localparam logic OPC_START = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GOAL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

	localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

endpackage

// ----- hw/rtl/grpc_cell.sv -----
// One operator slot of the rotating operator ring.
// Depends on grpc_pkg for field widths.
module grpc_cell #(
	parameter int NUM_PROPS = 64,
	parameter int IDX       = 0
) (
	input  logic                          clk,
	input  logic                          load_en,
	input  logic [grpc_pkg::IDX_W-1:0]    load_index,
	input  logic [NUM_PROPS-1:0]          load_pre,
	input  logic [NUM_PROPS-1:0]          load_eff,
	input  logic [grpc_pkg::OPCOST_W-1:0] load_cost,
	input  logic                          shift_en,
	input  logic [NUM_PROPS-1:0]          nxt_pre,
	input  logic [NUM_PROPS-1:0]          nxt_eff,
	input  logic [grpc_pkg::OPCOST_W-1:0] nxt_cost,
	output logic [NUM_PROPS-1:0]          pre,
	output logic [NUM_PROPS-1:0]          eff,
	output logic [grpc_pkg::OPCOST_W-1:0] cost
);

	logic [NUM_PROPS-1:0]          pre_q;
	logic [NUM_PROPS-1:0]          eff_q;
	logic [grpc_pkg::OPCOST_W-1:0] cost_q;
	logic                          hit;

	// loads only happen while the ring is aligned, so slot IDX holds operator IDX
	assign hit = load_en && ({2'b00, load_index} == 10'(IDX));

	always_ff @(posedge clk) begin
		if (shift_en) begin
			pre_q  <= nxt_pre;
			eff_q  <= nxt_eff;
			cost_q <= nxt_cost;
		end else if (hit) begin
			pre_q  <= load_pre;
			eff_q  <= load_eff;
			cost_q <= load_cost;
		end
	end

	assign pre  = pre_q;
	assign eff  = eff_q;
	assign cost = cost_q;

endmodule

// ----- hw/rtl/greedy_relaxed_plan_cost_core.sv -----
// Greedy relaxed-plan cost core: top level.
// Depends on grpc_pkg and grpc_cell.
//
// Operators sit in a ring of MAX_OPS cells that rotates one slot per cycle during the
// ring turn of a search; the head cell is evaluated against the reached set each cycle
// of that turn. A load request (opcode 0) gives no result. A start request runs rounds:
// a goal check, then one full ring turn that applies the first operator that fits.
// A search returns its result when the goal is met, or on a dead end (a turn that
// applies nothing). Busy stays high for the whole search; done pulses for one cycle
// with plan_cost and no_plan, and the receiver cannot hold it off.
module greedy_relaxed_plan_cost_core #(
	parameter int NUM_PROPS = 64,
	parameter int MAX_OPS   = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           opcode,
	input  logic [grpc_pkg::IDX_W-1:0]     op_index,
	input  logic [grpc_pkg::DATA_W-1:0]    pre_mask,
	input  logic [grpc_pkg::DATA_W-1:0]    eff_mask,
	input  logic [grpc_pkg::OPCOST_W-1:0]  op_cost,
	input  logic [grpc_pkg::DATA_W-1:0]    initial_mask,
	output logic                           done,
	output logic [grpc_pkg::COST_W-1:0]    plan_cost,
	output logic                           no_plan,
	input  logic                           cfg_we,
	input  logic [grpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [grpc_pkg::DATA_W-1:0]    cfg_data
);

	localparam int PW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
	localparam int CW = 11;
	localparam logic [PW-1:0] P_LAST = PW'(MAX_OPS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_SCAN} state_t;

	state_t                          state_q;
	logic [PW-1:0]                   p_q;
	logic [NUM_PROPS-1:0]            reached_q;
	logic [grpc_pkg::COST_W-1:0]     cost_q;
	logic                            applied_q;
	logic [NUM_PROPS-1:0]            goal_q;
	logic [grpc_pkg::COUNT_W-1:0]    count_q;
	logic                            done_q;
	logic [grpc_pkg::COST_W-1:0]     plan_cost_q;
	logic                            no_plan_q;

	logic [NUM_PROPS-1:0]            pre_a  [MAX_OPS];
	logic [NUM_PROPS-1:0]            eff_a  [MAX_OPS];
	logic [grpc_pkg::OPCOST_W-1:0]   cost_a [MAX_OPS];

	logic                            accept;
	logic                            load_en;
	logic                            shift_en;
	logic                            in_range;
	logic                            fits;
	logic                            goal_met;
	logic [grpc_pkg::COST_W:0]       sum;
	logic [grpc_pkg::COST_W-1:0]     sum_sat;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign load_en  = accept && (opcode == grpc_pkg::OPC_LOAD);
	assign shift_en = (state_q == ST_SCAN);

	genvar gi;
	generate
		for (gi = 0; gi < MAX_OPS; gi++) begin : g_ring
			grpc_cell #(
				.NUM_PROPS(NUM_PROPS),
				.IDX      (gi)
			) u_cell (
				.clk       (clk),
				.load_en   (load_en),
				.load_index(op_index),
				.load_pre  (pre_mask[NUM_PROPS-1:0]),
				.load_eff  (eff_mask[NUM_PROPS-1:0]),
				.load_cost (op_cost),
				.shift_en  (shift_en),
				.nxt_pre   (pre_a[(gi + 1) % MAX_OPS]),
				.nxt_eff   (eff_a[(gi + 1) % MAX_OPS]),
				.nxt_cost  (cost_a[(gi + 1) % MAX_OPS]),
				.pre       (pre_a[gi]),
				.eff       (eff_a[gi]),
				.cost      (cost_a[gi])
			);
		end
	endgenerate

	// head cell holds operator p_q; a used operator never fits again since its
	// effects are already reached, and one apply per turn keeps lowest-index order
	assign in_range = CW'(p_q) < CW'(count_q);
	assign fits     = in_range && !applied_q
			&& ((pre_a[0] & ~reached_q) == '0)
			&& ((eff_a[0] & ~reached_q) != '0);
	assign goal_met = ((goal_q & ~reached_q) == '0);
	assign sum      = {1'b0, cost_q} + (grpc_pkg::COST_W + 1)'(cost_a[0]);
	assign sum_sat  = sum[grpc_pkg::COST_W] ? grpc_pkg::COST_SAT
			: sum[grpc_pkg::COST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				grpc_pkg::REG_GOAL:  goal_q  <= cfg_data[NUM_PROPS-1:0];
				grpc_pkg::REG_COUNT: count_q <= cfg_data[grpc_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			p_q         <= '0;
			reached_q   <= '0;
			cost_q      <= '0;
			applied_q   <= 1'b0;
			done_q      <= 1'b0;
			plan_cost_q <= '0;
			no_plan_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == grpc_pkg::OPC_START)) begin
						reached_q <= initial_mask[NUM_PROPS-1:0];
						cost_q    <= '0;
						p_q       <= '0;
						state_q   <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					applied_q <= 1'b0;
					if (goal_met) begin
						done_q      <= 1'b1;
						plan_cost_q <= cost_q;
						no_plan_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fits) begin
						reached_q <= reached_q | eff_a[0];
						cost_q    <= sum_sat;
						applied_q <= 1'b1;
					end
					if (p_q == P_LAST) begin
						p_q <= '0;
						if (applied_q || fits) begin
							state_q <= ST_CHECK;
						end else begin
							done_q      <= 1'b1;
							plan_cost_q <= '0;
							no_plan_q   <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else begin
						p_q <= p_q + PW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign plan_cost = plan_cost_q;
	assign no_plan   = no_plan_q;

	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && no_plan_q |-> plan_cost_q == '0)
		else $error("dead end reported with nonzero cost");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("back-to-back results");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == grpc_pkg::OPC_START |=> busy)
		else $error("search request did not raise busy");

	a_aligned_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> p_q == '0)
		else $error("ring left misaligned");

endmodule
